/* hdl/ttms_pkg.sv */
// shared constants and helpers for the time text to milliseconds parser
`default_nettype none

package ttms_pkg;

  localparam logic [7:0] CHAR_COMMA = 8'd44;
  localparam logic [7:0] CHAR_DOT   = 8'd46;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_COLON = 8'd58;
  localparam logic [7:0] CHAR_FOUR  = 8'd52;

  localparam logic signed [11:0] MUL_COLON = 12'sd60;
  localparam logic signed [11:0] MUL_DOT   = 12'sd1000;
  localparam logic signed [11:0] MUL_DIGIT = 12'sd10;

  localparam logic signed [31:0] ERROR_TOTAL = -32'sd1000;

  localparam logic [1:0] MAX_COLONS    = 2'd1;
  localparam logic [2:0] FRAC_DIGITS   = 3'd3;

  // true when a 64-bit value fits a 32-bit two's complement word
  function automatic logic fits32(input logic signed [63:0] v);
    fits32 = (v[63:31] == {33{v[31]}});
  endfunction

  // scale that pads the fraction to three digits
  function automatic logic signed [11:0] pad_scale(input logic [2:0] frac);
    logic signed [11:0] s;
    s = 12'sd1;
    unique case (frac)
      3'd0:    s = 12'sd1000;
      3'd1:    s = 12'sd100;
      3'd2:    s = 12'sd10;
      default: s = 12'sd1;
    endcase
    pad_scale = s;
  endfunction

endpackage

`default_nettype wire

/* hdl/time_text_to_milliseconds_core.sv */
// time text to milliseconds parser, top level
`default_nettype none

// Usage
//   in_*  : one character per beat, in_tdata holds the character code and
//           in_tlast marks the final character of the string.
//   out_* : one beat per string, sent for the beat that carried in_tlast.
//           out_tdata holds the total in milliseconds (two's complement),
//           out_tuser[0] is the format-error status, out_tuser[1] the wrap flag.
// Throughput: one character per cycle, but a last one waits on a stalled output.
// A final character passes from the input register through the parse stage
//   to the finishing register, then finishing multiply and add, to out_*.
// The parse stage updates the running state with one constant multiply and
//   adds per character; finishing pads the fraction or scales seconds, and sums.
// Characters that are not last keep flowing while the output is stalled;
//   only a last character waits for room in the finishing and output stages.
// Reset (rst_n low, synchronous) empties all stages and clears the parse
//   state; the state also clears by itself after every last character.
module time_text_to_milliseconds_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_code
  input  wire logic        in_tlast,   // is_last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] total_milliseconds
  output logic [1:0]       out_tuser   // [0] status, [1] overflowed
);
  import ttms_pkg::*;

  // input register
  logic       a_v_r, a_v_nxt;
  logic [7:0] a_char_r;
  logic       a_last_r;

  // parse state
  logic signed [31:0] folded_r, folded_nxt;
  logic signed [31:0] cur_r, cur_nxt;
  logic [1:0]         colon_r, colon_nxt;
  logic               dot_r, dot_nxt;
  logic [2:0]         frac_r, frac_nxt;
  logic               stop_r, stop_nxt;
  logic               ferr_r, ferr_nxt;
  logic               wrap_r, wrap_nxt;

  // finishing stage snapshot
  logic               b_v_r;
  logic signed [31:0] b_folded_r, b_cur_r;
  logic               b_dot_r, b_ferr_r, b_wrap_r;
  logic [2:0]         b_frac_r;

  // output register
  logic               o_v_r;
  logic signed [31:0] o_total_r;
  logic               o_status_r, o_ovf_r;

  logic o_free, b_free, a_consume, in_acc, b_load;

  assign o_free    = !o_v_r || out_tready;
  assign b_free    = !b_v_r || o_free;
  assign a_consume = a_v_r && (!a_last_r || b_free);
  assign in_tready = !a_v_r || a_consume;
  assign in_acc    = in_tvalid && in_tready;
  assign b_load    = a_consume && a_last_r;

  always_comb begin
    a_v_nxt = a_v_r;
    if (in_acc) begin
      a_v_nxt = 1'b1;
    end else if (a_consume) begin
      a_v_nxt = 1'b0;
    end
  end

  // per character parse step
  logic signed [32:0] fsum;
  logic signed [31:0] fsum_w;
  logic signed [11:0] fmul;
  logic signed [63:0] fprod;
  logic signed [63:0] p10;
  logic signed [9:0]  digit;
  logic signed [63:0] dsum;
  logic signed [32:0] inc;
  logic               is_colon;

  always_comb begin
    is_colon = (a_char_r == CHAR_COLON) && !dot_r;
    fsum     = 33'(folded_r) + 33'(cur_r);
    fsum_w   = fsum[31:0];
    fmul     = is_colon ? MUL_COLON : MUL_DOT;
    fprod    = 64'(fsum_w) * 64'(fmul);
    p10      = 64'(cur_r) * 64'(MUL_DIGIT);
    digit    = signed'({2'b00, a_char_r}) - signed'({2'b00, CHAR_ZERO});
    dsum     = 64'(signed'(p10[31:0])) + 64'(digit);
    inc      = 33'(cur_r) + 33'sd1;

    folded_nxt = folded_r;
    cur_nxt    = cur_r;
    colon_nxt  = colon_r;
    dot_nxt    = dot_r;
    frac_nxt   = frac_r;
    stop_nxt   = stop_r;
    ferr_nxt   = ferr_r;
    wrap_nxt   = wrap_r;

    if (!stop_r) begin
      priority if (a_char_r == CHAR_COMMA) begin
        stop_nxt = 1'b1;
      end else if (is_colon) begin
        if (colon_r > MAX_COLONS) begin
          ferr_nxt = 1'b1;
          stop_nxt = 1'b1;
        end else begin
          folded_nxt = fprod[31:0];
          cur_nxt    = '0;
          colon_nxt  = colon_r + 2'd1;
          wrap_nxt   = wrap_r || !fits32(64'(fsum)) || !fits32(fprod);
        end
      end else if (a_char_r == CHAR_DOT) begin
        if (dot_r) begin
          ferr_nxt = 1'b1;
          stop_nxt = 1'b1;
        end else begin
          folded_nxt = fprod[31:0];
          cur_nxt    = '0;
          dot_nxt    = 1'b1;
          wrap_nxt   = wrap_r || !fits32(64'(fsum)) || !fits32(fprod);
        end
      end else if (dot_r && frac_r >= FRAC_DIGITS) begin
        // fourth fraction character rounds and ends the parse
        frac_nxt = frac_r + 3'd1;
        stop_nxt = 1'b1;
        if (a_char_r > CHAR_FOUR) begin
          cur_nxt  = inc[31:0];
          wrap_nxt = wrap_r || !fits32(64'(inc));
        end
      end else begin
        if (dot_r) begin
          frac_nxt = frac_r + 3'd1;
        end
        cur_nxt  = dsum[31:0];
        wrap_nxt = wrap_r || !fits32(p10) || !fits32(dsum);
      end
    end
  end

  // finishing step: pad the fraction or scale seconds, then sum
  logic signed [63:0] pprod;
  logic signed [32:0] psum;
  logic signed [32:0] nsum;
  logic signed [63:0] nprod;
  logic signed [31:0] fin_total;
  logic               fin_ovf;

  always_comb begin
    pprod = 64'(b_cur_r) * 64'(pad_scale(b_frac_r));
    psum  = 33'(b_folded_r) + 33'(signed'(pprod[31:0]));
    nsum  = 33'(b_folded_r) + 33'(b_cur_r);
    nprod = 64'(signed'(nsum[31:0])) * 64'(MUL_DOT);
    priority if (b_ferr_r) begin
      fin_total = ERROR_TOTAL;
      fin_ovf   = b_wrap_r;
    end else if (b_dot_r) begin
      fin_total = psum[31:0];
      fin_ovf   = b_wrap_r || !fits32(pprod) || !fits32(64'(psum));
    end else begin
      fin_total = nprod[31:0];
      fin_ovf   = b_wrap_r || !fits32(64'(nsum)) || !fits32(nprod);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r    <= 1'b0;
      b_v_r    <= 1'b0;
      o_v_r    <= 1'b0;
      folded_r <= '0;
      cur_r    <= '0;
      colon_r  <= '0;
      dot_r    <= 1'b0;
      frac_r   <= '0;
      stop_r   <= 1'b0;
      ferr_r   <= 1'b0;
      wrap_r   <= 1'b0;
    end else begin
      a_v_r <= a_v_nxt;
      if (a_consume) begin
        if (a_last_r) begin
          // string done, start the next one from a clean state
          folded_r <= '0;
          cur_r    <= '0;
          colon_r  <= '0;
          dot_r    <= 1'b0;
          frac_r   <= '0;
          stop_r   <= 1'b0;
          ferr_r   <= 1'b0;
          wrap_r   <= 1'b0;
        end else begin
          folded_r <= folded_nxt;
          cur_r    <= cur_nxt;
          colon_r  <= colon_nxt;
          dot_r    <= dot_nxt;
          frac_r   <= frac_nxt;
          stop_r   <= stop_nxt;
          ferr_r   <= ferr_nxt;
          wrap_r   <= wrap_nxt;
        end
      end
      if (b_load) begin
        b_v_r <= 1'b1;
      end else if (o_free) begin
        b_v_r <= 1'b0;
      end
      if (o_free) begin
        o_v_r <= b_v_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_char_r <= in_tdata;
      a_last_r <= in_tlast;
    end
    if (b_load) begin
      b_folded_r <= folded_nxt;
      b_cur_r    <= cur_nxt;
      b_dot_r    <= dot_nxt;
      b_frac_r   <= frac_nxt;
      b_ferr_r   <= ferr_nxt;
      b_wrap_r   <= wrap_nxt;
    end
    if (o_free && b_v_r) begin
      o_total_r  <= fin_total;
      o_status_r <= b_ferr_r;
      o_ovf_r    <= fin_ovf;
    end
  end

  assign out_tvalid = o_v_r;
  assign out_tdata  = o_total_r;
  assign out_tuser  = {o_ovf_r, o_status_r};

endmodule

`default_nettype wire
